// ----- rtl/core/tdma_pkg.sv -----
`timescale 1ns / 1ps

package tdma_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = 7;
  localparam int ADDR_W    = 16;
  localparam int WANT_W    = 8;
  localparam int ST_W      = 3;
  localparam int CMD_W     = 2;
  localparam int REG_IDX_W = 2;
  localparam int REG_W     = 16;
  localparam int DIV_STEPS = CNT_W;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ASSOC = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_STATIC  = 3'd1;
  localparam logic [ST_W-1:0] ST_BADADDR = 3'd2;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
  localparam logic [ST_W-1:0] ST_BADIDX  = 3'd5;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_SLOTS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OWN_ADDR    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STATIC_MODE = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_FREE  = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_BCAST = 16'hFFFF;

  localparam logic [CNT_W-1:0]  FRAME_SLOTS_RST = 7'd64;
  localparam logic [ADDR_W-1:0] OWN_ADDR_RST    = 16'h0001;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_DIV,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    SEL_IDX,
    SEL_SCAN,
    SEL_ID
  } addr_sel_t;

  typedef struct packed {
    logic [CNT_W-1:0]  frame_slots;
    logic [ADDR_W-1:0] own_addr;
    logic              static_mode;
  } cfg_t;

  typedef struct packed {
    logic            load_in;
    logic            set_st;
    logic [ST_W-1:0] st;
    logic            take_owner;
    logic            take_left;
    logic            mem_rd;
    logic            mem_wr;
    addr_sel_t       addr_sel;
    logic            div_start;
    logic            div_step;
    logic            scan_next;
    logic            scan_take;
    logic            req_dec;
    logic            place_base;
    logic            probe_next;
    logic            out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             idx_ok;
    logic             is_static;
    logic             bad_addr;
    logic             want_zero;
    logic             n_zero;
    logic             div_last;
    logic             scan_end;
    logic             req_zero;
    logic             rd_match;
    logic             rd_free;
    logic             probe_wrap;
    logic             out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/tdma_in_if.sv -----
`timescale 1ns / 1ps

interface tdma_in_if import tdma_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  slot_index;
  logic [ADDR_W-1:0] node_addr;
  logic [WANT_W-1:0] slots_wanted;

  modport source (
    output valid, command, slot_index, node_addr, slots_wanted,
    input  ready
  );

  modport sink (
    input  valid, command, slot_index, node_addr, slots_wanted,
    output ready
  );
endinterface

// ----- rtl/core/tdma_out_if.sv -----
`timescale 1ns / 1ps

interface tdma_out_if import tdma_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [WANT_W-1:0] left_unallocated;
  logic [ADDR_W-1:0] owner_read;

  modport source (
    output valid, status, left_unallocated, owner_read,
    input  ready
  );

  modport sink (
    input  valid, status, left_unallocated, owner_read,
    output ready
  );
endinterface

// ----- rtl/core/tdma_cfg.sv -----
`timescale 1ns / 1ps

module tdma_cfg import tdma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  logic [CNT_W-1:0]  frame_slots_r;
  logic [ADDR_W-1:0] own_addr_r;
  logic              static_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_slots_r <= FRAME_SLOTS_RST;
      own_addr_r    <= OWN_ADDR_RST;
      static_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_SLOTS: frame_slots_r <= cfg_wdata[CNT_W-1:0];
        REG_OWN_ADDR:    own_addr_r    <= cfg_wdata[ADDR_W-1:0];
        REG_STATIC_MODE: static_mode_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.frame_slots = frame_slots_r;
  assign cfg.own_addr    = own_addr_r;
  assign cfg.static_mode = static_mode_r;

endmodule

// ----- rtl/core/tdma_dp.sv -----
`timescale 1ns / 1ps

module tdma_dp import tdma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [ADDR_W-1:0] in_node_addr,
  input  logic [WANT_W-1:0] in_slots_wanted,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic [WANT_W-1:0] out_left,
  output logic [ADDR_W-1:0] out_owner
);

  logic [CMD_W-1:0]  cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WANT_W-1:0] want_r;
  logic [WANT_W-1:0] req_r;
  logic [ST_W-1:0]   st_r;
  logic [WANT_W-1:0] left_r;
  logic [ADDR_W-1:0] owner_r;
  logic [WANT_W-1:0] rem_r;
  logic [CNT_W-1:0]  qd_r;
  logic [2:0]        div_cnt_r;
  logic [CNT_W-1:0]  scan_r;
  logic [IDX_W-1:0]  id_r;
  logic [IDX_W-1:0]  base_r;

  logic [ADDR_W-1:0] mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid_r;
  logic [ADDR_W-1:0] rd_data_r;
  logic              rd_vld_r;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [WANT_W-1:0] out_left_r;
  logic [ADDR_W-1:0] out_owner_r;

  logic [CNT_W-1:0]  n;
  logic [WANT_W:0]   rem_t;
  logic [WANT_W:0]   rem_sub;
  logic              rem_ge;
  logic [WANT_W-1:0] rem_nxt;
  logic [CNT_W-1:0]  sum_base;
  logic [CNT_W-1:0]  sum_wrap;
  logic [IDX_W-1:0]  base_nxt;
  logic [CNT_W-1:0]  id_inc;
  logic [IDX_W-1:0]  id_inc_nxt;
  logic [ADDR_W-1:0] rd_word;
  logic [IDX_W-1:0]  mem_addr;

  assign n = (cfg.frame_slots > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cfg.frame_slots;

  assign rem_t   = {rem_r, qd_r[CNT_W-1]};
  assign rem_ge  = rem_t >= {1'b0, want_r};
  assign rem_sub = rem_t - {1'b0, want_r};
  assign rem_nxt = rem_ge ? rem_sub[WANT_W-1:0] : rem_t[WANT_W-1:0];

  assign sum_base = {1'b0, id_r} + qd_r;
  assign sum_wrap = sum_base - n;
  assign base_nxt = (sum_base >= n) ? sum_wrap[IDX_W-1:0] : sum_base[IDX_W-1:0];

  assign id_inc     = {1'b0, id_r} + CNT_W'(1);
  assign id_inc_nxt = (id_inc >= n) ? '0 : id_inc[IDX_W-1:0];

  assign rd_word = rd_vld_r ? rd_data_r : ADDR_FREE;

  always_comb begin
    case (cmd.addr_sel)
      SEL_IDX:  mem_addr = idx_r;
      SEL_SCAN: mem_addr = scan_r[IDX_W-1:0];
      SEL_ID:   mem_addr = id_r;
      default:  mem_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[mem_addr] <= addr_r;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[mem_addr];
      rd_vld_r  <= valid_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.mem_wr) begin
      valid_r[mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r   <= in_command;
      idx_r   <= in_slot_index;
      addr_r  <= in_node_addr;
      want_r  <= in_slots_wanted;
      req_r   <= in_slots_wanted;
      left_r  <= '0;
      owner_r <= '0;
      id_r    <= '0;
      scan_r  <= '0;
    end else begin
      if (cmd.req_dec) begin
        req_r <= req_r - WANT_W'(1);
      end
      if (cmd.take_left) begin
        left_r <= req_r;
      end
      if (cmd.take_owner) begin
        owner_r <= rd_word;
      end
      if (cmd.scan_next) begin
        scan_r <= scan_r + CNT_W'(1);
      end
      if (cmd.scan_take) begin
        id_r <= scan_r[IDX_W-1:0];
      end else if (cmd.place_base) begin
        id_r <= base_nxt;
      end else if (cmd.probe_next) begin
        id_r <= id_inc_nxt;
      end
    end
    if (cmd.place_base) begin
      base_r <= base_nxt;
    end
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
    if (cmd.div_start) begin
      rem_r     <= '0;
      qd_r      <= n;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      qd_r      <= {qd_r[CNT_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_left_r   <= left_r;
      out_owner_r  <= owner_r;
    end
  end

  assign sts.command    = cmd_r;
  assign sts.idx_ok     = {1'b0, idx_r} < n;
  assign sts.is_static  = cfg.static_mode;
  assign sts.bad_addr   = (addr_r == ADDR_FREE) || (addr_r == ADDR_BCAST) ||
                          (addr_r == cfg.own_addr);
  assign sts.want_zero  = want_r == '0;
  assign sts.n_zero     = n == '0;
  assign sts.div_last   = div_cnt_r == 3'(DIV_STEPS - 1);
  assign sts.scan_end   = scan_r >= n;
  assign sts.req_zero   = req_r == '0;
  assign sts.rd_match   = rd_word == addr_r;
  assign sts.rd_free    = rd_word == ADDR_FREE;
  assign sts.probe_wrap = id_inc_nxt == base_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_left   = out_left_r;
  assign out_owner  = out_owner_r;

endmodule

// ----- rtl/core/tdma_ctrl.sv -----
`timescale 1ns / 1ps

module tdma_ctrl import tdma_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_st = 1'b1;
        cmd.st     = ST_OK;
        state_nxt  = S_RESP;
        case (sts.command)
          CMD_WRITE: begin
            if (sts.idx_ok) begin
              cmd.mem_wr   = 1'b1;
              cmd.addr_sel = SEL_IDX;
            end else begin
              cmd.st = ST_BADIDX;
            end
          end
          CMD_READ: begin
            if (sts.idx_ok) begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = SEL_IDX;
              state_nxt    = S_RD_WAIT;
            end else begin
              cmd.st = ST_BADIDX;
            end
          end
          CMD_ASSOC: begin
            if (sts.is_static) begin
              cmd.st = ST_STATIC;
            end else if (sts.bad_addr) begin
              cmd.st = ST_BADADDR;
            end else if (sts.want_zero) begin
              cmd.st = ST_ZERO;
            end else if (sts.n_zero) begin
              cmd.st        = ST_FULL;
              cmd.take_left = 1'b1;
            end else begin
              cmd.set_st    = 1'b0;
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.st = ST_BADIDX;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.take_owner = 1'b1;
        state_nxt      = S_RESP;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end || sts.req_zero) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = SEL_SCAN;
          state_nxt    = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.scan_next = 1'b1;
        if (sts.rd_match) begin
          cmd.scan_take = 1'b1;
          cmd.req_dec   = 1'b1;
        end
        state_nxt = S_SCAN_RD;
      end
      S_PLACE: begin
        if (sts.req_zero) begin
          cmd.set_st    = 1'b1;
          cmd.st        = ST_OK;
          cmd.take_left = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.place_base = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = SEL_ID;
        state_nxt    = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (sts.rd_free) begin
          cmd.mem_wr   = 1'b1;
          cmd.addr_sel = SEL_ID;
          cmd.req_dec  = 1'b1;
          state_nxt    = S_PLACE;
        end else if (sts.probe_wrap) begin
          cmd.set_st    = 1'b1;
          cmd.st        = ST_FULL;
          cmd.take_left = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/tdma_slot_allocator_top.sv -----
`timescale 1ns / 1ps
// Slot-owner table of a TDMA coordinator with association handling.
// Commands arrive as items on in_chan (valid/ready); each command gives exactly
// one result item on out_chan, in order. The user must write registers through the
// cfg_we/cfg_idx/cfg_wdata port only while no command is in progress; the block
// itself does not enforce this. The block works on one command at a time:
// in_chan.ready is high only while the controller is idle. A write or a bad
// command passes through the decode and response states before its result is
// loaded into the output register and the next item can be taken; a read also
// passes through a read-wait state, as the table is a memory with a registered
// read port. A rejected request takes the same path as a write.
// An association then runs the step division, scans the table entries for slots
// already owned, and makes placement attempts, each probing the single memory
// port for a free entry, until every slot is placed or the table is full.
// Reset clears every slot to free at once through per-slot valid bits and
// restores a frame of 64 slots, own address 1 and static mode off.
// The output register holds a result until it is taken. While it waits, one
// further item may be accepted and worked on, after which the controller holds
// in its response state and no new item is accepted.

module tdma_slot_allocator_top import tdma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tdma_in_if.sink              in_chan,
  tdma_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  tdma_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tdma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdma_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_command      (in_chan.command),
    .in_slot_index   (in_chan.slot_index),
    .in_node_addr    (in_chan.node_addr),
    .in_slots_wanted (in_chan.slots_wanted),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_left        (out_chan.left_unallocated),
    .out_owner       (out_chan.owner_read)
  );

endmodule

// ----- sim/tdma_slot_allocator_checker.sv -----
`timescale 1ns / 1ps

module tdma_slot_allocator_checker import tdma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tdma_in_if                   in_mon,
  tdma_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata,
  output int                   pending,
  output int                   fail_count
);

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [WANT_W-1:0] left;
    logic [ADDR_W-1:0] owner;
  } alloc_result_t;

  logic [ADDR_W-1:0] owner_tab [MAX_SLOTS];
  logic [CNT_W-1:0]  frame_slots_r;
  logic [ADDR_W-1:0] own_addr_r;
  logic              static_r;
  alloc_result_t     result_q [$];

  function automatic int live_slots();
    return (int'(frame_slots_r) > MAX_SLOTS) ? MAX_SLOTS : int'(frame_slots_r);
  endfunction

  // Slots the node already holds count towards the request; the rest are
  // spread by a fixed stride and then probed upwards for a free entry.
  function automatic logic [WANT_W-1:0] place_slots(input logic [ADDR_W-1:0] node,
                                                     input logic [WANT_W-1:0] wanted);
    int n;
    int stride;
    int last;
    int base;
    int remaining;
    n = live_slots();
    remaining = int'(wanted);
    if (n == 0) return wanted;
    stride = n / remaining;
    last = 0;
    for (int i = 0; i < n && remaining != 0; i++) begin
      if (owner_tab[i] == node) begin
        last = i;
        remaining--;
      end
    end
    while (remaining != 0) begin
      base = (last + stride) % n;
      last = base;
      while (owner_tab[last] != ADDR_FREE) begin
        last = (last + 1) % n;
        if (last == base) break;
      end
      if (owner_tab[last] != ADDR_FREE) break;
      owner_tab[last] = node;
      remaining--;
    end
    return remaining[WANT_W-1:0];
  endfunction

  function automatic alloc_result_t predict_command(input logic [CMD_W-1:0]  cmd,
                                                    input logic [IDX_W-1:0]  idx,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [WANT_W-1:0] want);
    alloc_result_t res;
    int n;
    res = '0;
    n = live_slots();
    case (cmd)
      CMD_WRITE: begin
        if (int'(idx) < n) owner_tab[idx] = addr;
        else res.status = ST_BADIDX;
      end
      CMD_READ: begin
        if (int'(idx) < n) res.owner = owner_tab[idx];
        else res.status = ST_BADIDX;
      end
      CMD_ASSOC: begin
        if (static_r) begin
          res.status = ST_STATIC;
        end else if (addr == ADDR_FREE || addr == ADDR_BCAST || addr == own_addr_r) begin
          res.status = ST_BADADDR;
        end else if (want == '0) begin
          res.status = ST_ZERO;
        end else begin
          res.left = place_slots(addr, want);
          res.status = (res.left != '0) ? ST_FULL : ST_OK;
        end
      end
      default: res.status = ST_BADIDX;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t expected_r;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) owner_tab[i] = ADDR_FREE;
      frame_slots_r = FRAME_SLOTS_RST;
      own_addr_r = OWN_ADDR_RST;
      static_r = 1'b0;
      result_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status = out_mon.status;
        got.left = out_mon.left_unallocated;
        got.owner = out_mon.owner_read;
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result item status=%0d left=%0d owner=%h",
                     $realtime, got.status, got.left, got.owner);
        end else begin
          expected_r = result_q.pop_front();
          if (got.status !== expected_r.status || got.left !== expected_r.left ||
              got.owner !== expected_r.owner) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch: expected status=%0d left=%0d owner=%h, ",
                        "got status=%0d left=%0d owner=%h"},
                       $realtime, expected_r.status, expected_r.left, expected_r.owner,
                       got.status, got.left, got.owner);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_FRAME_SLOTS: frame_slots_r = cfg_wdata[CNT_W-1:0];
          REG_OWN_ADDR:    own_addr_r = cfg_wdata[ADDR_W-1:0];
          REG_STATIC_MODE: static_r = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(predict_command(in_mon.command, in_mon.slot_index,
                                           in_mon.node_addr, in_mon.slots_wanted));
    end
    pending = result_q.size();
  end

endmodule

// ----- sim/tb_tdma_slot_allocator_top.sv -----
`timescale 1ns / 1ps

module tb_tdma_slot_allocator_top;
  import tdma_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_wdata;
  logic                 rx_ready = 1'b0;
  int                   pending;
  int                   fail_count;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   slots_live = MAX_SLOTS;
  logic [ADDR_W-1:0]    own_live = OWN_ADDR_RST;

  tdma_in_if  in_chan ();
  tdma_out_if out_chan ();

  assign out_chan.ready = rx_ready;

  tdma_slot_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tdma_slot_allocator_checker alloc_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    rx_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(input logic [CMD_W-1:0]  cmd,
                           input logic [IDX_W-1:0]  idx,
                           input logic [ADDR_W-1:0] addr,
                           input logic [WANT_W-1:0] want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.command      <= cmd;
    in_chan.slot_index   <= idx;
    in_chan.node_addr    <= addr;
    in_chan.slots_wanted <= want;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic configure(input logic [CNT_W-1:0] count, input logic [ADDR_W-1:0] own,
                           input logic stat);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FRAME_SLOTS;
    cfg_wdata <= REG_W'(count);
    @(negedge clk);
    cfg_idx   <= REG_OWN_ADDR;
    cfg_wdata <= own;
    @(negedge clk);
    cfg_idx   <= REG_STATIC_MODE;
    cfg_wdata <= REG_W'(stat);
    @(negedge clk);
    cfg_we <= 1'b0;
    slots_live = (int'(count) > MAX_SLOTS) ? MAX_SLOTS : int'(count);
    own_live = own;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if (slots_live == 0 || $urandom_range(0, 3) == 0)
      return IDX_W'($urandom_range(0, MAX_SLOTS - 1));
    return IDX_W'($urandom_range(0, slots_live - 1));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_node();
    case ($urandom_range(0, 9))
      0: return ADDR_FREE;
      1: return ADDR_BCAST;
      2: return own_live;
      3, 4: return ADDR_W'($urandom_range(0, 16'hFFFF));
      default: return ADDR_W'(16'h0010 + $urandom_range(0, 3));
    endcase
  endfunction

  // A small pool of node addresses keeps requests meeting slots already owned.
  task automatic send_random();
    int r;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] node;
    logic [WANT_W-1:0] count;
    r = $urandom_range(0, 99);
    node = ADDR_W'($urandom_range(0, 16'hFFFF));
    count = WANT_W'($urandom_range(0, 255));
    if (r < 40) begin
      cmd = CMD_WRITE;
      node = ($urandom_range(0, 1) == 0) ? ADDR_FREE : pick_node();
    end else if (r < 65) begin
      cmd = CMD_READ;
    end else if (r < 95) begin
      cmd = CMD_ASSOC;
      node = pick_node();
      case ($urandom_range(0, 9))
        0: count = '0;
        1: ;
        default: count = WANT_W'($urandom_range(1, 4));
      endcase
    end else begin
      cmd = CMD_UNUSED;
    end
    send_item(cmd, pick_index(), node, count);
  endtask

  task automatic run_phase(input int items, input logic [CNT_W-1:0] count,
                           input logic [ADDR_W-1:0] own, input logic stat,
                           input int idle, input int stall);
    configure(count, own, stat);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain();
      send_random();
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_chan.valid        = 1'b0;
    in_chan.command      = CMD_WRITE;
    in_chan.slot_index   = '0;
    in_chan.node_addr    = '0;
    in_chan.slots_wanted = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(CMD_READ,   6'd0,  16'h0000, 8'd0);
    send_item(CMD_WRITE,  6'd0,  ADDR_BCAST, 8'd0);
    send_item(CMD_WRITE,  6'd63, 16'h1234, 8'd0);
    send_item(CMD_READ,   6'd63, 16'hFFFF, 8'hFF);
    send_item(CMD_UNUSED, 6'd0,  16'h0010, 8'd1);
    send_item(CMD_ASSOC,  6'd0,  ADDR_FREE, 8'd1);
    send_item(CMD_ASSOC,  6'd0,  ADDR_BCAST, 8'd1);
    send_item(CMD_ASSOC,  6'd0,  OWN_ADDR_RST, 8'd1);
    send_item(CMD_ASSOC,  6'd0,  16'h0010, 8'd0);
    send_item(CMD_ASSOC,  6'd0,  16'h0010, 8'd3);
    send_item(CMD_ASSOC,  6'd0,  16'h0010, 8'd2);
    send_item(CMD_ASSOC,  6'd0,  16'h0020, 8'd255);
    send_item(CMD_READ,   6'd5,  16'h0000, 8'd0);

    configure(7'd8, OWN_ADDR_RST, 1'b1);
    send_item(CMD_ASSOC,  6'd0,  16'h0030, 8'd1);
    send_item(CMD_WRITE,  6'd8,  16'h0030, 8'd0);
    send_item(CMD_READ,   6'd7,  16'h0000, 8'd0);
    send_item(CMD_WRITE,  6'd7,  ADDR_FREE, 8'd0);

    configure(7'd0, 16'hFFFF, 1'b0);
    send_item(CMD_WRITE,  6'd0,  16'h0040, 8'd0);
    send_item(CMD_READ,   6'd0,  16'h0000, 8'd0);
    send_item(CMD_ASSOC,  6'd0,  16'h0040, 8'd5);

    configure(7'd127, 16'h0000, 1'b0);
    send_item(CMD_READ,   6'd63, 16'h0000, 8'd0);
    send_item(CMD_WRITE,  6'd40, ADDR_FREE, 8'd0);
    send_item(CMD_ASSOC,  6'd0,  16'h0001, 8'd2);

    run_phase(30, 7'd64, 16'h0002, 1'b0, 0,  0);
    run_phase(20, 7'd1,  16'hFFFF, 1'b0, 60, 0);
    run_phase(30, 7'd37, 16'h8000, 1'b0, 0,  60);
    run_phase(30, 7'd16, 16'h0003, 1'b0, 26, 26);
    run_phase(10, 7'd64, 16'h0001, 1'b1, 26, 26);

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
